>>> rtl/bfn_pkg.sv
package bfn_pkg;

    localparam int ACT_W = 3;
    localparam int IDX_W = 9;
    localparam int POS_W = 8;
    localparam int POP_W = 9;

    // request actions
    localparam logic [ACT_W-1:0] A_SET     = 3'd0;
    localparam logic [ACT_W-1:0] A_CLR     = 3'd1;
    localparam logic [ACT_W-1:0] A_TEST    = 3'd2;
    localparam logic [ACT_W-1:0] A_FIRST   = 3'd3;
    localparam logic [ACT_W-1:0] A_NEXT    = 3'd4;
    localparam logic [ACT_W-1:0] A_LAST    = 3'd5;
    localparam logic [ACT_W-1:0] A_CLR_ALL = 3'd6;

    // word pointer start point
    localparam logic [1:0] PTR_ZERO = 2'd0;
    localparam logic [1:0] PTR_TOP  = 2'd1;
    localparam logic [1:0] PTR_WORD = 2'd2;

    typedef struct packed {
        logic             capture;
        logic             split;
        logic             err;
        logic [1:0]       ptr_init;
        logic             rd_en;
        logic             modify;
        logic             eval;
        logic             ptr_step;
        logic             clear_all;
        logic             out_load;
        logic [ACT_W-1:0] action;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_oor;
        logic found;
        logic last_word;
    } t_dp_stat;

endpackage

>>> rtl/bfn_ram.sv
module bfn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/bfn_ctrl.sv
module bfn_ctrl
    import bfn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPLIT = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [ACT_W-1:0] r_action, n_action;
    logic             r_out_valid, n_out_valid;
    logic             uses_index;
    logic             is_find;

    assign uses_index = (r_action == A_SET) || (r_action == A_CLR) ||
                        (r_action == A_TEST) || (r_action == A_NEXT);
    assign is_find    = (r_action == A_FIRST) || (r_action == A_NEXT) ||
                        (r_action == A_LAST);

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        o_cmd        = '0;
        o_cmd.action = r_action;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_action      = i_action;
                    n_state       = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                o_cmd.err   = uses_index && i_stat.idx_oor;
                if (o_cmd.err) begin
                    n_state = S_DONE;
                end else begin
                    unique case (r_action) inside
                        A_SET, A_CLR, A_TEST, A_NEXT: begin
                            o_cmd.ptr_init = PTR_WORD;
                            n_state        = S_READ;
                        end
                        A_FIRST: begin
                            o_cmd.ptr_init = PTR_ZERO;
                            n_state        = S_READ;
                        end
                        A_LAST: begin
                            o_cmd.ptr_init = PTR_TOP;
                            n_state        = S_READ;
                        end
                        A_CLR_ALL: begin
                            o_cmd.clear_all = 1'b1;
                            n_state         = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = is_find ? S_EVAL : S_MOD;
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
                n_state      = S_DONE;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.found || i_stat.last_word) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.ptr_step = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_action    <= A_SET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an unread result");

    a_accept_to_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SPLIT))
        else $error("accepted item did not start decode");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.out_load))
        else $error("output valid rose without a result load");

endmodule

>>> rtl/bfn_dp.sv
module bfn_dp
    import bfn_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [IDX_W-1:0] i_bit_index,
    output t_dp_stat         o_stat,
    output logic             o_hit,
    output logic [POS_W-1:0] o_position,
    output logic [POP_W-1:0] o_population,
    output logic             o_range_error
);

    localparam int MAP_BITS = WORD_BITS * NUM_WORDS;
    localparam int MAP_W    = $clog2(MAP_BITS + 1);
    localparam int CMP_W    = (MAP_W > IDX_W) ? MAP_W : IDX_W;
    localparam int WIDX_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W    = $clog2(WORD_BITS);
    // index / WORD_BITS by reciprocal; estimate is exact or one low
    localparam int DIV_K    = 18;
    localparam int RECIP    = (2 ** DIV_K) / WORD_BITS;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = IDX_W + RECIP_W;
    localparam int QW       = $clog2((2 ** IDX_W) / WORD_BITS + 1);

    logic [IDX_W-1:0]     r_idx;
    logic [PROD_W-1:0]    r_prod;
    logic [WIDX_W-1:0]    r_word;
    logic [BIT_W-1:0]     r_bit;
    logic [WIDX_W-1:0]    r_ptr;
    logic [NUM_WORDS-1:0] r_valid;
    logic [POP_W-1:0]     r_count;
    logic                 r_err;
    logic                 r_res_hit;
    logic [POS_W-1:0]     r_res_pos;

    logic [QW-1:0]        q_est, q_fix;
    logic [IDX_W-1:0]     rem_est, rem_fix;
    logic [WORD_BITS-1:0] rd_data, word, bit_mask, hi_mask, scan_word, word_rev;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;
    logic                 bit_val;
    logic                 nonzero;
    logic [BIT_W-1:0]     enc;
    logic [CMP_W-1:0]     found_pos;

    function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_BITS-1:0] x);
        logic [WORD_BITS-1:0] oh;
        logic [BIT_W-1:0]     e;
        oh = x & (~x + WORD_BITS'(1));
        e  = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                e = e | BIT_W'(i);
            end
        end
        return e;
    endfunction

    // index split into word and bit
    always_comb begin
        q_est   = QW'(r_prod >> DIV_K);
        rem_est = r_idx - IDX_W'(q_est * WORD_BITS);
        if (rem_est >= IDX_W'(WORD_BITS)) begin
            q_fix   = q_est + QW'(1);
            rem_fix = rem_est - IDX_W'(WORD_BITS);
        end else begin
            q_fix   = q_est;
            rem_fix = rem_est;
        end
    end

    assign o_stat.idx_oor = (CMP_W'(r_idx) >= CMP_W'(MAP_BITS));

    bfn_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_ptr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    // a word never written since reset or clear-all reads as zero
    assign word = r_valid[r_ptr] ? rd_data : '0;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            bit_mask[i] = (BIT_W'(i) == r_bit);
            hi_mask[i]  = !((i_cmd.action == A_NEXT) && (r_ptr == r_word)) ||
                          (BIT_W'(i) > r_bit);
            word_rev[i] = scan_word[WORD_BITS-1-i];
        end
    end

    assign bit_val   = |(word & bit_mask);
    assign scan_word = word & hi_mask;
    assign nonzero   = |scan_word;
    assign enc       = (i_cmd.action == A_LAST) ?
                       (BIT_W'(WORD_BITS - 1) - f_lowest(word_rev)) : f_lowest(scan_word);
    assign found_pos = CMP_W'(r_ptr) * CMP_W'(WORD_BITS) + CMP_W'(enc);

    assign o_stat.found     = nonzero;
    assign o_stat.last_word = (i_cmd.action == A_LAST) ? (r_ptr == '0) :
                              (r_ptr == WIDX_W'(NUM_WORDS - 1));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = word;
        if (i_cmd.modify) begin
            if (i_cmd.action == A_SET && !bit_val) begin
                wr_en   = 1'b1;
                wr_data = word | bit_mask;
            end else if (i_cmd.action == A_CLR && bit_val) begin
                wr_en   = 1'b1;
                wr_data = word & ~bit_mask;
            end
        end
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_err     <= 1'b0;
            r_res_hit <= 1'b0;
            r_res_pos <= '0;
        end else begin
            if (i_cmd.split) begin
                r_err     <= i_cmd.err;
                r_res_hit <= 1'b0;
                r_res_pos <= '0;
            end
            if (i_cmd.clear_all) begin
                r_valid <= '0;
                r_count <= '0;
            end
            if (wr_en) begin
                r_valid[r_ptr] <= 1'b1;
                r_count <= (i_cmd.action == A_SET) ? r_count + POP_W'(1) :
                                                     r_count - POP_W'(1);
            end
            if (i_cmd.modify && i_cmd.action == A_TEST) begin
                r_res_hit <= bit_val;
            end
            if (i_cmd.eval && nonzero) begin
                r_res_hit <= 1'b1;
                r_res_pos <= POS_W'(found_pos);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx  <= i_bit_index;
            r_prod <= PROD_W'(i_bit_index) * PROD_W'(RECIP);
        end
        if (i_cmd.split) begin
            r_word <= WIDX_W'(q_fix);
            r_bit  <= BIT_W'(rem_fix);
            case (i_cmd.ptr_init)
                PTR_TOP:  r_ptr <= WIDX_W'(NUM_WORDS - 1);
                PTR_WORD: r_ptr <= WIDX_W'(q_fix);
                default:  r_ptr <= '0;
            endcase
        end else if (i_cmd.ptr_step) begin
            r_ptr <= (i_cmd.action == A_LAST) ? r_ptr - WIDX_W'(1) : r_ptr + WIDX_W'(1);
        end
        if (i_cmd.out_load) begin
            o_hit         <= r_res_hit;
            o_position    <= r_res_pos;
            o_population  <= r_count;
            o_range_error <= r_err;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(MAP_BITS))
        else $error("population above map size");

    a_err_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err && r_res_hit))
        else $error("hit reported on a range error");

    a_pos_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_hit |-> (r_res_pos == '0))
        else $error("position without a hit");

endmodule

>>> rtl/bitset_find_next_engine_top.sv
// Steps per item: set/clear/test go through decode, word read and modify; find
//   through decode and a read and an evaluate state per word (up to NUM_WORDS);
//   clear-all, range error and undefined action go from decode to the result
//   load; the next item can be taken in the cycle after load. Find rate is
//   set by the controller, which spends a read and an evaluate state per word.
// Reset (synchronous, active low) empties the map and the count at once.
module bitset_find_next_engine_top
    import bfn_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [ACT_W-1:0] i_action,
    input  logic [IDX_W-1:0] i_bit_index,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_hit,
    output logic [POS_W-1:0] o_position,
    output logic [POP_W-1:0] o_population,
    output logic             o_range_error
);

    // Controller walks each item through decode and, as needed, word read(s)
    // and modify or evaluation; the datapath owns the map memory, its per-word valid
    // bits, the population counter and the result registers.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bfn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // The output register holds a finished item while the controller
    // already takes and works on the next one.
    bfn_dp #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_bit_index   (i_bit_index),
        .o_stat        (dp_stat),
        .o_hit         (o_hit),
        .o_position    (o_position),
        .o_population  (o_population),
        .o_range_error (o_range_error)
    );

endmodule

>>> tb/sv/bitset_find_next_engine_top_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the bit set engine.
// A directed table opens the run, then random blocks of requests follow.
// Each accepted item runs through a shadow copy of the map, which predicts
// the result; pinned table rows queue their typed-in result instead. The
// results queue up in order and are checked against the result channel.
module bitset_find_next_engine_top_tb
    import bfn_pkg::*;
();

    localparam int MAP_BITS = 256;
    // the 3-bit action field has one code with no action behind it
    localparam logic [ACT_W-1:0] A_UNDEF = 3'd7;

    localparam int RAND_ITEMS   = 1700;
    localparam int BLOCK_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 150;   // long result stall, fills the pipe
    localparam int DRAIN_CYCLES = 24;    // extra wait after the last owed result
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int NUM_ROWS     = 27;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] position;
        logic [POP_W-1:0] population;
        logic             range_error;
    } t_result;

    // one line of the directed table; pinned rows carry their result typed in
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] bit_index;
        logic             pinned;
        t_result          want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [ACT_W-1:0] i_action = '0;
    logic [IDX_W-1:0] i_bit_index = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_hit;
    logic [POS_W-1:0] o_position;
    logic [POP_W-1:0] o_population;
    logic             o_range_error;

    bitset_find_next_engine_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_bit_index   (i_bit_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_position    (o_position),
        .o_population  (o_population),
        .o_range_error (o_range_error)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow state of the block and the queue of results still owed.
    logic [MAP_BITS-1:0] shadow_map = '0;
    int unsigned         shadow_pop = 0;
    t_result             owed_results[$];
    int                  fail_count = 0;

    // Both sides run without gaps while calm is set, but for the long hold.
    bit calm = 1'b0;
    // Asks the result side for one long stall.
    bit hold_req = 1'b0;

    // Applies one request to the shadow map and returns its result.
    function automatic t_result bitset_apply(input logic [ACT_W-1:0] act,
                                             input logic [IDX_W-1:0] idx);
        t_result r;
        logic    uses_idx;
        int      p;
        r = '0;
        uses_idx = (act == A_SET) || (act == A_CLR) || (act == A_TEST) || (act == A_NEXT);
        if (uses_idx && idx >= MAP_BITS) begin
            // out of range: no state change, flag only
            r.range_error = 1'b1;
        end else begin
            case (act)
                A_SET: begin
                    if (!shadow_map[idx[7:0]]) begin
                        shadow_map[idx[7:0]] = 1'b1;
                        shadow_pop++;
                    end
                end
                A_CLR: begin
                    if (shadow_map[idx[7:0]]) begin
                        shadow_map[idx[7:0]] = 1'b0;
                        shadow_pop--;
                    end
                end
                A_TEST: begin
                    r.hit = shadow_map[idx[7:0]];
                end
                A_FIRST: begin
                    for (p = 0; p < MAP_BITS && !r.hit; p++) begin
                        if (shadow_map[p]) begin
                            r.hit = 1'b1;
                            r.position = POS_W'(p);
                        end
                    end
                end
                A_NEXT: begin
                    // strictly above the index; top bit finds nothing
                    for (p = int'(idx) + 1; p < MAP_BITS && !r.hit; p++) begin
                        if (shadow_map[p]) begin
                            r.hit = 1'b1;
                            r.position = POS_W'(p);
                        end
                    end
                end
                A_LAST: begin
                    for (p = MAP_BITS - 1; p >= 0 && !r.hit; p--) begin
                        if (shadow_map[p]) begin
                            r.hit = 1'b1;
                            r.position = POS_W'(p);
                        end
                    end
                end
                A_CLR_ALL: begin
                    shadow_map = '0;
                    shadow_pop = 0;
                end
                default: ;   // undefined action, nothing happens
            endcase
        end
        r.population = POP_W'(shadow_pop);
        return r;
    endfunction

    function automatic t_row mk_row(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                    input logic pinned, input logic hit,
                                    input logic [POS_W-1:0] pos, input logic [POP_W-1:0] pop,
                                    input logic err);
        t_row row;
        row.action = act;
        row.bit_index = idx;
        row.pinned = pinned;
        row.want.hit = hit;
        row.want.position = pos;
        row.want.population = pop;
        row.want.range_error = err;
        return row;
    endfunction

    // Action mix for the random blocks; set_pct steers the map density.
    function automatic logic [ACT_W-1:0] pick_action(input int set_pct);
        int r;
        if ($urandom_range(0, 99) < set_pct) return A_SET;
        r = $urandom_range(0, 19);
        if (r < 5) return A_CLR;
        if (r < 7) return A_TEST;
        if (r < 9) return A_FIRST;
        if (r < 15) return A_NEXT;
        if (r < 17) return A_LAST;
        if (r < 19) return A_TEST;
        return ($urandom_range(0, 3) == 0) ? A_CLR_ALL : A_UNDEF;
    endfunction

    // Mostly in range, some beyond the map, some on word edges.
    function automatic logic [IDX_W-1:0] pick_index();
        int e;
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom_range(MAP_BITS, 511));
            1: begin
                e = $urandom_range(0, 3);
                e = (e < 2) ? e : e + 60;   // bits 0, 1, 62, 63 of a word
                return IDX_W'($urandom_range(0, 3) * 64 + e);
            end
            default: return IDX_W'($urandom_range(0, MAP_BITS - 1));
        endcase
    endfunction

    // Offers one item, waits for it to be taken and queues its result.
    // Entered and left at a falling edge.
    task automatic offer(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                         input logic pinned, input t_result want);
        int      gap;
        t_result got;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action = act;
        i_bit_index = idx;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = bitset_apply(act, idx);
        owed_results.push_back(pinned ? want : got);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_count++;
        end
    endtask

    // Result side: a fresh stall draw per item, plus the one long hold.
    initial begin : result_sink
        int n;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = calm ? 0 : $urandom_range(0, 3);
            end
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Every taken result against the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                $error("result with none outstanding");
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                check_field("hit", 16'(want.hit), 16'(o_hit));
                check_field("position", 16'(want.position), 16'(o_position));
                check_field("population", 16'(want.population), 16'(o_population));
                check_field("range_error", 16'(want.range_error), 16'(o_range_error));
            end
        end
    end

    // Hang detection: any handshake on either side clears the count.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row             rows [NUM_ROWS];
        int               i;
        int               blk;
        int               k;
        int               set_pct;
        logic [ACT_W-1:0] act;

        rows = '{
            // empty map straight after reset
            mk_row(A_FIRST,   9'd0,   1'b1, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_LAST,    9'd0,   1'b1, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_NEXT,    9'd0,   1'b1, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_TEST,    9'd255, 1'b1, 1'b0, 8'd0,   9'd0, 1'b0),
            // both ends of the map; second set of the same bit keeps the count
            mk_row(A_SET,     9'd0,   1'b1, 1'b0, 8'd0,   9'd1, 1'b0),
            mk_row(A_SET,     9'd255, 1'b1, 1'b0, 8'd0,   9'd2, 1'b0),
            mk_row(A_SET,     9'd255, 1'b1, 1'b0, 8'd0,   9'd2, 1'b0),
            mk_row(A_TEST,    9'd255, 1'b1, 1'b1, 8'd0,   9'd2, 1'b0),
            mk_row(A_FIRST,   9'd0,   1'b1, 1'b1, 8'd0,   9'd2, 1'b0),
            mk_row(A_LAST,    9'd0,   1'b1, 1'b1, 8'd255, 9'd2, 1'b0),
            mk_row(A_NEXT,    9'd0,   1'b1, 1'b1, 8'd255, 9'd2, 1'b0),
            // find next from the top bit finds nothing
            mk_row(A_NEXT,    9'd255, 1'b1, 1'b0, 8'd0,   9'd2, 1'b0),
            // indices beyond the map
            mk_row(A_SET,     9'd256, 1'b1, 1'b0, 8'd0,   9'd2, 1'b1),
            mk_row(A_CLR,     9'd511, 1'b1, 1'b0, 8'd0,   9'd2, 1'b1),
            mk_row(A_TEST,    9'd300, 1'b1, 1'b0, 8'd0,   9'd2, 1'b1),
            mk_row(A_NEXT,    9'd511, 1'b1, 1'b0, 8'd0,   9'd2, 1'b1),
            // index ignored by find first / last
            mk_row(A_FIRST,   9'd511, 1'b1, 1'b1, 8'd0,   9'd2, 1'b0),
            mk_row(A_LAST,    9'd511, 1'b1, 1'b1, 8'd255, 9'd2, 1'b0),
            // undefined action
            mk_row(A_UNDEF,   9'h155, 1'b1, 1'b0, 8'd0,   9'd2, 1'b0),
            mk_row(A_UNDEF,   9'h0AA, 1'b0, 1'b0, 8'd0,   9'd0, 1'b0),
            // word boundary between words 0 and 1
            mk_row(A_SET,     9'd64,  1'b0, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_SET,     9'd63,  1'b0, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_NEXT,    9'd63,  1'b0, 1'b0, 8'd0,   9'd0, 1'b0),
            // clear, then clear of a bit already clear
            mk_row(A_CLR,     9'd0,   1'b0, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_CLR,     9'd0,   1'b0, 1'b0, 8'd0,   9'd0, 1'b0),
            // clear all empties map and count
            mk_row(A_CLR_ALL, 9'h1FF, 1'b1, 1'b0, 8'd0,   9'd0, 1'b0),
            mk_row(A_LAST,    9'd0,   1'b1, 1'b0, 8'd0,   9'd0, 1'b0)
        };

        // reset released on a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (i = 0; i < NUM_ROWS; i++) begin
            offer(rows[i].action, rows[i].bit_index, rows[i].pinned, rows[i].want);
        end

        // Random blocks. Each picks its own density and idling; about half
        // start from an empty map so that sparse maps get searched too.
        for (blk = 0; blk < RAND_ITEMS / BLOCK_ITEMS; blk++) begin
            calm = ($urandom_range(0, 3) == 0);
            set_pct = $urandom_range(3, 45);
            if (blk == 4) begin
                // result side stalls for a long stretch, input keeps coming
                calm = 1'b1;
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                offer(A_CLR_ALL, IDX_W'($urandom), 1'b0, '0);
            end
            for (k = 0; k < BLOCK_ITEMS; k++) begin
                act = pick_action(set_pct);
                offer(act, pick_index(), 1'b0, '0);
            end
        end
        i_in_valid = 1'b0;

        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/bfn_pkg.sv
rtl/bfn_ram.sv
rtl/bfn_ctrl.sv
rtl/bfn_dp.sv
rtl/bitset_find_next_engine_top.sv
tb/sv/bitset_find_next_engine_top_tb.sv
